// File: design/boxdiff_pkg.sv
// ----------------------------------------------------------------------------
// boxdiff_pkg
// Shared types, the piece table and the sorting function for the box
// difference block.
// ----------------------------------------------------------------------------
package boxdiff_pkg;

  localparam int CoordW   = 8;
  localparam int NumPieces = 6;
  localparam int QDepth   = 2;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  typedef logic [CoordW-1:0] coord_t;
  typedef coord_t [3:0]      coord4_t;

  typedef struct packed {
    coord_t outer_ax;
    coord_t outer_ay;
    coord_t outer_az;
    coord_t outer_bx;
    coord_t outer_by;
    coord_t outer_bz;
    coord_t inner_ax;
    coord_t inner_ay;
    coord_t inner_az;
    coord_t inner_bx;
    coord_t inner_by;
    coord_t inner_bz;
  } in_word_t;

  typedef struct packed {
    coord_t     piece_low_x;
    coord_t     piece_low_y;
    coord_t     piece_low_z;
    coord_t     piece_high_x;
    coord_t     piece_high_y;
    coord_t     piece_high_z;
    logic [2:0] piece_slot;
    logic       piece_last;
  } out_word_t;

  // four coordinates of each axis, ascending
  typedef struct packed {
    coord4_t x;
    coord4_t y;
    coord4_t z;
  } sorted_t;

  typedef enum logic [2:0] {
    SLOT_POS_Y = 3'd0,
    SLOT_NEG_Y = 3'd1,
    SLOT_POS_X = 3'd2,
    SLOT_NEG_X = 3'd3,
    SLOT_POS_Z = 3'd4,
    SLOT_NEG_Z = 3'd5
  } slot_e;

  // per slot: sorted index of low x, low y, low z, high x, high y, high z
  localparam logic [1:0] PieceTbl [NumPieces][6] = '{
    '{2'd0, 2'd2, 2'd0, 2'd3, 2'd3, 2'd3},
    '{2'd0, 2'd0, 2'd0, 2'd3, 2'd1, 2'd3},
    '{2'd2, 2'd1, 2'd0, 2'd3, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd3},
    '{2'd1, 2'd1, 2'd0, 2'd2, 2'd2, 2'd1}
  };

  // five compare-exchange steps, three levels deep
  function automatic coord4_t sort4(coord_t a, coord_t b, coord_t c, coord_t d);
    coord_t l0, h0, l1, h1, lo, m0, m1, hi;
    l0 = (a > b) ? b : a;
    h0 = (a > b) ? a : b;
    l1 = (c > d) ? d : c;
    h1 = (c > d) ? c : d;
    lo = (l0 > l1) ? l1 : l0;
    m0 = (l0 > l1) ? l0 : l1;
    m1 = (h0 > h1) ? h1 : h0;
    hi = (h0 > h1) ? h0 : h1;
    sort4[0] = lo;
    sort4[1] = (m0 > m1) ? m1 : m0;
    sort4[2] = (m0 > m1) ? m0 : m1;
    sort4[3] = hi;
  endfunction

endpackage

// File: design/boxdiff_front.sv
// ----------------------------------------------------------------------------
// boxdiff_front
// Accepts a box pair, sorts the coordinates of each axis and holds the
// sorted word until the queue takes it.
// ----------------------------------------------------------------------------
module boxdiff_front import boxdiff_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_word_t item_i,
  output logic     fwd_valid_o,
  input  logic     fwd_ready_i,
  output sorted_t  fwd_word_o
);

  logic    valid_q, valid_d;
  sorted_t word_q;
  logic    take;

  assign full = valid_q && !fwd_ready_i;
  assign take = push && !full;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (fwd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      word_q.x <= sort4(item_i.outer_ax, item_i.outer_bx, item_i.inner_ax, item_i.inner_bx);
      word_q.y <= sort4(item_i.outer_ay, item_i.outer_by, item_i.inner_ay, item_i.inner_by);
      word_q.z <= sort4(item_i.outer_az, item_i.outer_bz, item_i.inner_az, item_i.inner_bz);
    end
  end

  assign fwd_valid_o = valid_q;
  assign fwd_word_o  = word_q;

endmodule

// File: design/boxdiff_queue.sv
// ----------------------------------------------------------------------------
// boxdiff_queue
// Short queue of sorted words between the front and the back end.
// ----------------------------------------------------------------------------
module boxdiff_queue import boxdiff_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    enq_valid_i,
  output logic    enq_ready_o,
  input  sorted_t enq_word_i,
  output logic    deq_valid_o,
  input  logic    deq_ready_i,
  output sorted_t deq_word_o
);

  sorted_t          mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q, count_d;
  logic             enq, deq;

  assign enq_ready_o = (count_q != QCntW'(QDepth));
  assign deq_valid_o = (count_q != '0);
  assign enq = enq_valid_i && enq_ready_o;
  assign deq = deq_ready_i && deq_valid_o;

  always_comb begin
    count_d = count_q;
    if (enq && !deq) begin
      count_d = count_q + QCntW'(1);
    end else if (deq && !enq) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (enq) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (deq) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      mem_q[wr_ptr_q] <= enq_word_i;
    end
  end

  assign deq_word_o = mem_q[rd_ptr_q];

endmodule

// File: design/boxdiff_back.sv
// ----------------------------------------------------------------------------
// boxdiff_back
// Walks the six slots of the head word into the output register, one
// piece per cycle while the register is empty or popped.
// ----------------------------------------------------------------------------
module boxdiff_back import boxdiff_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  output logic      head_ready_o,
  input  sorted_t   head_word_i,
  output logic      empty,
  input  logic      pop,
  output out_word_t piece_o
);

  slot_e     slot_q, slot_d;
  logic      out_valid_q, out_valid_d;
  out_word_t out_q, piece;
  logic      load, last;

  assign load = head_valid_i && (!out_valid_q || pop);
  assign last = (slot_q == SLOT_NEG_Z);
  assign head_ready_o = load && last;

  always_comb begin
    piece.piece_low_x  = head_word_i.x[PieceTbl[slot_q][0]];
    piece.piece_low_y  = head_word_i.y[PieceTbl[slot_q][1]];
    piece.piece_low_z  = head_word_i.z[PieceTbl[slot_q][2]];
    piece.piece_high_x = head_word_i.x[PieceTbl[slot_q][3]];
    piece.piece_high_y = head_word_i.y[PieceTbl[slot_q][4]];
    piece.piece_high_z = head_word_i.z[PieceTbl[slot_q][5]];
    piece.piece_slot   = slot_q;
    piece.piece_last   = last;
  end

  always_comb begin
    slot_d      = slot_q;
    out_valid_d = out_valid_q;
    if (load) begin
      slot_d      = last ? SLOT_POS_Y : slot_e'(slot_q + 3'd1);
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= SLOT_POS_Y;
      out_valid_q <= 1'b0;
    end else begin
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= piece;
    end
  end

  assign empty   = !out_valid_q;
  assign piece_o = out_q;

endmodule

// File: design/box_difference_six_slabs.sv
// ----------------------------------------------------------------------------
// box_difference_six_slabs
// Splits an outer box minus an inner box into six slab boxes.
//
//   channel  | handshake   | word
//   ---------+-------------+---------------------------------
//   input    | push / full | item_i  : two boxes, two corners
//   result   | empty / pop | piece_o : one slab, slot, last
//
// Each input word yields six result words, one per cycle while pop keeps
// the output register free; the back end's slot counter walks the six.
// The first piece passes the sort register, loaded at the accepting edge,
// then a queue entry and then the output register before it is on piece_o.
// Reset clears the valid flags, queue pointers and slot counter. Either
// side may stall; the queue lets the front keep sorting.
// ----------------------------------------------------------------------------
module box_difference_six_slabs import boxdiff_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_word_t  item_i,
  output logic      empty,
  input  logic      pop,
  output out_word_t piece_o
);

  logic    fwd_valid, fwd_ready;
  sorted_t fwd_word;
  logic    head_valid, head_ready;
  sorted_t head_word;

  boxdiff_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .fwd_valid_o (fwd_valid),
    .fwd_ready_i (fwd_ready),
    .fwd_word_o  (fwd_word)
  );

  boxdiff_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enq_valid_i (fwd_valid),
    .enq_ready_o (fwd_ready),
    .enq_word_i  (fwd_word),
    .deq_valid_o (head_valid),
    .deq_ready_i (head_ready),
    .deq_word_o  (head_word)
  );

  boxdiff_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_ready_o (head_ready),
    .head_word_i  (head_word),
    .empty        (empty),
    .pop          (pop),
    .piece_o      (piece_o)
  );

endmodule
